>>> hw/rtl/isr_pkg.sv
// Shared types and constants for the integer square root pipeline.
`default_nettype none

package isr_pkg;

	localparam int unsigned RADICAND_W = 32;
	localparam int unsigned ROOT_W     = 16;
	localparam int unsigned OUT_W      = 24;
	localparam int unsigned STAGES     = RADICAND_W / 2;

	typedef struct packed {
		logic [RADICAND_W-1:0] rem;
		logic [RADICAND_W-1:0] res;
	} stage_t;

endpackage

`default_nettype wire

>>> hw/rtl/isr_stage.sv
// One registered step of the restoring digit-by-digit square root.
`default_nettype none

module isr_stage #(
	parameter int unsigned STEP = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  valid_in,
	input  isr_pkg::stage_t      data_in,
	output logic                 valid_s,
	output isr_pkg::stage_t      data_s
);

	localparam logic [isr_pkg::RADICAND_W-1:0] BIT =
		isr_pkg::RADICAND_W'(1) << (isr_pkg::RADICAND_W - 2 - 2 * STEP);

	logic [isr_pkg::RADICAND_W:0] trial;
	logic                         fits;
	isr_pkg::stage_t              next;

	// The trial value is kept one bit wider so the compare never wraps.
	assign trial = {1'b0, data_in.res} + {1'b0, BIT};
	assign fits  = {1'b0, data_in.rem} >= trial;

	always_comb begin
		if (fits) begin
			next.rem = data_in.rem - trial[isr_pkg::RADICAND_W-1:0];
			next.res = (data_in.res >> 1) + BIT;
		end else begin
			next.rem = data_in.rem;
			next.res = data_in.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else begin
			valid_s <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		data_s <= next;
	end

endmodule

`default_nettype wire

>>> hw/rtl/integer_square_root_fixed.sv
// Integer square root with a fixed-point scaled result: one transfer per clock cycle.
// Each start with a 32-bit radicand returns floor(sqrt(radicand)) shifted left by
// FRACTION_BITS/2 and cut to 24 bits. The unit is a 16-stage pipeline that resolves
// one root bit per stage, so a new radicand is taken in every cycle and its result
// appears with done high when it leaves the last stage, for one cycle. busy is always low;
// the receiver must take each result in the cycle that done is high.
`default_nettype none

module integer_square_root_fixed #(
	parameter int unsigned FRACTION_BITS = 16
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  wire  [isr_pkg::RADICAND_W-1:0]    radicand,
	output logic                              done,
	output logic [isr_pkg::OUT_W-1:0]         root_fixed
);

	localparam int unsigned SHIFT   = FRACTION_BITS / 2;
	localparam int unsigned WIDE_W  = isr_pkg::ROOT_W + SHIFT;

	logic            stage_valid [0:isr_pkg::STAGES];
	isr_pkg::stage_t stage_data  [0:isr_pkg::STAGES];
	logic [WIDE_W-1:0]                wide_root;
	logic [WIDE_W+isr_pkg::OUT_W-1:0] padded_root;

	// The pipeline never stalls, so every start is a transfer.
	assign busy = 1'b0;

	assign stage_valid[0]    = start;
	assign stage_data[0].rem = radicand;
	assign stage_data[0].res = '0;

	for (genvar g = 0; g < isr_pkg::STAGES; g++) begin : g_stage
		isr_stage #(
			.STEP(g)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_in(stage_valid[g]),
			.data_in (stage_data[g]),
			.valid_s (stage_valid[g+1]),
			.data_s  (stage_data[g+1])
		);
	end

	assign wide_root   = WIDE_W'(stage_data[isr_pkg::STAGES].res[isr_pkg::ROOT_W-1:0]) << SHIFT;
	assign padded_root = {{isr_pkg::OUT_W{1'b0}}, wide_root};
	assign root_fixed  = padded_root[isr_pkg::OUT_W-1:0];
	assign done        = stage_valid[isr_pkg::STAGES];

endmodule

`default_nettype wire

>>> sim/tb_integer_square_root_fixed.sv
// Self-checking testbench for the pipelined fixed-point integer square root.
module tb_integer_square_root_fixed;

	localparam int unsigned FRACTION_BITS = 16;
	localparam logic [31:0] TOP_SQUARE = 32'hFFFE_0001;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic [isr_pkg::RADICAND_W-1:0] radicand = '0;
	logic                          busy;
	logic                          done;
	logic [isr_pkg::OUT_W-1:0]     root_fixed;

	logic [isr_pkg::OUT_W-1:0] pending_roots[$];
	logic [isr_pkg::OUT_W-1:0] next_root;
	int n_sent = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_top_range = 0;
	int burst_left = 0;

	integer_square_root_fixed #(
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.radicand(radicand),
		.done(done),
		.root_fixed(root_fixed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Floor root by trying each root bit from the top down, then the fixed-point shift.
	function automatic logic [isr_pkg::OUT_W-1:0] calc_root_fixed(input logic [31:0] value);
		logic [15:0] root;
		logic [15:0] trial;
		logic [63:0] scaled;
		root = '0;
		for (int b = 15; b >= 0; b--) begin
			trial = root | (16'd1 << b);
			if ({16'd0, trial} * {16'd0, trial} <= value)
				root = trial;
		end
		scaled = 64'(root) << (FRACTION_BITS / 2);
		return scaled[isr_pkg::OUT_W-1:0];
	endfunction

	// Results cannot be held off, so every done pulse is checked at the edge that ends it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1) begin
				if (pending_roots.size() == 0) begin
					$display("%0t: unexpected root: expected none, actual 0x%06h",
						$time, root_fixed);
					n_errors++;
				end else begin
					next_root = pending_roots.pop_front();
					n_checked++;
					if (root_fixed !== next_root) begin
						$display("%0t: root_fixed mismatch: expected 0x%06h, actual 0x%06h",
							$time, next_root, root_fixed);
						n_errors++;
					end
				end
			end
			if (start && busy === 1'b0)
				pending_roots.push_back(calc_root_fixed(radicand));
		end
	end

	task automatic send_radicand(input logic [31:0] value);
		start <= 1'b1;
		radicand <= value;
		do @(posedge clk); while (busy !== 1'b0);
		n_sent++;
		if (value >= TOP_SQUARE)
			n_top_range++;
	endtask

	// Idle cycles carry junk on the data port; it must be ignored.
	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			radicand <= $urandom;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic next_burst_slot();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			pause_sender($urandom_range(1, 6));
			burst_left = $urandom_range(0, 40);
		end
	endtask

	task automatic wait_for_all_roots();
		start <= 1'b0;
		while (n_checked < n_sent) @(posedge clk);
	endtask

	task automatic test_boundary_values();
		logic [31:0] edges[$];
		edges = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd255, 32'd256, 32'h0000_FFFF,
			32'h0001_0000, 32'h00FF_FFFF, 32'h0100_0000, 32'h3FFF_FFFF, 32'h4000_0000,
			32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFE_0000, TOP_SQUARE, 32'hFFFF_0000,
			32'hFFFF_FFFE, 32'hFFFF_FFFF};
		// Back to back at full rate, then once more with a gap after every transfer.
		foreach (edges[i])
			send_radicand(edges[i]);
		foreach (edges[i]) begin
			send_radicand(edges[i]);
			pause_sender(1);
		end
	endtask

	task automatic test_square_neighbors();
		logic [63:0] n;
		logic [63:0] sq;
		for (int k = 0; k < 100; k++) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 65535);
			if (k == 0)
				n = 65535;
			sq = n * n;
			if (n > 0) begin
				next_burst_slot();
				send_radicand(32'(sq - 1));
			end
			next_burst_slot();
			send_radicand(32'(sq));
			next_burst_slot();
			send_radicand(32'(sq + 2 * n));
		end
	endtask

	task automatic test_random_stream(input int count);
		logic [31:0] value;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 3))
				0: value = $urandom;
				1: value = $urandom >> $urandom_range(0, 31);
				2: value = TOP_SQUARE + $urandom_range(0, 32'h0001_FFFE);
				default: value = $urandom_range(0, 1023);
			endcase
			// Once midway, let the pipeline empty completely before going on.
			if (k == count / 2)
				wait_for_all_roots();
			next_burst_slot();
			send_radicand(value);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_boundary_values();
		test_square_neighbors();
		test_random_stream(1280);
		wait_for_all_roots();
		repeat (isr_pkg::STAGES + 8) @(posedge clk);
		if (pending_roots.size() != 0) begin
			$display("%0t: %0d expected roots never arrived", $time, pending_roots.size());
			n_errors++;
		end
		$display("Sent %0d radicands (edges, squares and neighbors, mixed magnitudes), %0d",
			n_sent, n_top_range);
		$display("of them in the saturated top range; %0d roots compared, %0d errors.",
			n_checked, n_errors);
		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout at %0t with %0d roots outstanding", $time, pending_roots.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
